// File: rtl/twfc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the trie word frequency counter.
// Depends on nothing; the top level and twfc_out_reg import it.
package twfc_pkg;

  localparam int NODES_DEF    = 4096;
  localparam int ALPHABET_DEF = 26;

  localparam int SYMBOL_W = 5;
  localparam int NODE_W   = 12;
  localparam int TOTAL_W  = 32;

  localparam logic STATUS_COUNTED = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0]  word_node;
    logic [TOTAL_W-1:0] word_total;
    logic [NODE_W-1:0]  best_node;
    logic [TOTAL_W-1:0] best_total;
    logic               status;
  } result_t;

endpackage

// File: rtl/trie_word_frequency_counter_unit.sv
`timescale 1ns / 1ps
// Trie word frequency counter, top level. Uses twfc_pkg, twfc_ram and twfc_out_reg.
// A symbol passes through S_IDLE (row read) and S_LOOK (decide), and also S_CLEAR when it
// allocates a node, S_COUNT when it counts an existing end node, or S_LOOK once more when it
// fills the pool on a word's final symbol. A result is loaded from S_LOOK for a dropped word,
// else from S_CLEAR or S_COUNT; each waits while result_stall keeps the output register full.
// Reset sets the control registers but sym_q and slot_q; root row reads empty until written.
module trie_word_frequency_counter_unit
  import twfc_pkg::*;
#(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Symbol request channel.
  input  logic                symbol_valid,
  output logic                symbol_stall,
  input  logic [SYMBOL_W-1:0] symbol,
  input  logic                last,
  // Result channel.
  output logic                result_valid,
  input  logic                result_stall,
  output logic [NODE_W-1:0]   word_node,
  output logic [TOTAL_W-1:0]  word_total,
  output logic [NODE_W-1:0]   best_node,
  output logic [TOTAL_W-1:0]  best_total,
  output logic                status
);

  // Node index, symbol index and child table address widths, child table depth, node row width.
  localparam int NW = $clog2(NODES);
  localparam int SW = $clog2(ALPHABET);
  localparam int CD = NODES * ALPHABET;
  localparam int AW = $clog2(CD);
  localparam int RW = ALPHABET + TOTAL_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_CLEAR,
    S_COUNT
  } state_t;

  // Control registers.
  state_t          state, state_next;
  logic [SW-1:0]   sym_q, sym_q_next;
  logic            last_q, last_q_next;
  logic [AW-1:0]   slot_q, slot_q_next;
  logic [NW-1:0]   walk, walk_next;
  logic [NW:0]     next_free, next_free_next;
  logic [NW-1:0]   top_node, top_node_next;
  logic [TOTAL_W-1:0] top_total, top_total_next;
  logic            dropping, dropping_next;
  logic            root_init, root_init_next;

  // Memory ports.
  logic            child_rd_en, child_wr_en;
  logic [AW-1:0]   child_rd_addr;
  logic [NW-1:0]   child_rd_data;
  logic            node_rd_en, node_wr_en;
  logic [NW-1:0]   node_rd_addr, node_wr_addr;
  logic [RW-1:0]   node_rd_data, node_wr_data;

  // Output register handshake.
  logic            emit, slot_free;
  result_t         emit_data, out_data;

  // The incoming symbol is clamped to the last letter of the alphabet.
  logic [SW-1:0]   sym_in;
  logic [AW-1:0]   slot_in;

  always_comb begin
    if (int'(symbol) >= ALPHABET) begin
      sym_in = SW'(ALPHABET - 1);
    end else begin
      sym_in = SW'(symbol);
    end
  end

  // Each node owns ALPHABET consecutive child table entries.
  assign slot_in = AW'(walk) * AW'(ALPHABET) + AW'(sym_in);

  // Fields of the node row just read. The root row has never been written after reset
  // until root_init is set, so its child bits count as clear until then.
  logic [ALPHABET-1:0] row_present;
  logic [TOTAL_W-1:0]  row_total;
  logic [ALPHABET-1:0] sym_bit;
  logic                has_child;
  logic                pool_full;
  logic [NW-1:0]       fresh;

  always_comb begin
    if (walk == '0 && !root_init) begin
      row_present = '0;
    end else begin
      row_present = node_rd_data[RW-1:TOTAL_W];
    end
  end

  assign row_total = node_rd_data[TOTAL_W-1:0];
  assign sym_bit   = ALPHABET'(1) << sym_q;
  assign has_child = row_present[sym_q];
  assign pool_full = (next_free == (NW+1)'(NODES));
  assign fresh     = next_free[NW-1:0];

  // Candidate for the running maximum. A freshly allocated end node always counts one;
  // otherwise the stored count goes up by one and saturates.
  logic [TOTAL_W-1:0] cand_total;
  logic               cand_better;

  always_comb begin
    if (state == S_CLEAR) begin
      cand_total = TOTAL_W'(1);
    end else if (row_total == '1) begin
      cand_total = row_total;
    end else begin
      cand_total = row_total + TOTAL_W'(1);
    end
  end

  // Ties go to the lower node index.
  assign cand_better = (cand_total > top_total) ||
                       (cand_total == top_total && walk < top_node);

  always_comb begin
    state_next     = state;
    sym_q_next     = sym_q;
    last_q_next    = last_q;
    slot_q_next    = slot_q;
    walk_next      = walk;
    next_free_next = next_free;
    top_node_next  = top_node;
    top_total_next = top_total;
    dropping_next  = dropping;
    root_init_next = root_init;

    child_rd_en    = 1'b0;
    child_rd_addr  = slot_in;
    child_wr_en    = 1'b0;
    node_rd_en     = 1'b0;
    node_rd_addr   = walk;
    node_wr_en     = 1'b0;
    node_wr_addr   = walk;
    node_wr_data   = '0;
    emit           = 1'b0;
    emit_data      = '0;

    case (state)
      S_IDLE: begin
        // Read the current node's row and the child slot in parallel.
        if (symbol_valid) begin
          child_rd_en  = 1'b1;
          node_rd_en   = 1'b1;
          sym_q_next   = sym_in;
          last_q_next  = last;
          slot_q_next  = slot_in;
          state_next   = S_LOOK;
        end
      end

      S_LOOK: begin
        if (dropping) begin
          // The rest of this word is discarded; its final symbol reports the drop.
          if (!last_q) begin
            state_next = S_IDLE;
          end else if (slot_free) begin
            emit                 = 1'b1;
            emit_data.best_node  = NODE_W'(top_node);
            emit_data.best_total = top_total;
            emit_data.status     = STATUS_DROPPED;
            walk_next            = '0;
            dropping_next        = 1'b0;
            state_next           = S_IDLE;
          end
        end else if (has_child) begin
          walk_next = child_rd_data;
          if (last_q) begin
            // Fetch the end node's count for the update.
            node_rd_en   = 1'b1;
            node_rd_addr = child_rd_data;
            state_next   = S_COUNT;
          end else begin
            state_next = S_IDLE;
          end
        end else if (pool_full) begin
          // Revisit this state so a final symbol reports through the drop path.
          dropping_next = 1'b1;
          state_next    = last_q ? S_LOOK : S_IDLE;
        end else begin
          // Link a new child and mark it present in the parent's row.
          child_wr_en    = 1'b1;
          node_wr_en     = 1'b1;
          node_wr_data   = {row_present | sym_bit, row_total};
          root_init_next = root_init || (walk == '0);
          next_free_next = next_free + (NW+1)'(1);
          walk_next      = fresh;
          state_next     = S_CLEAR;
        end
      end

      S_CLEAR: begin
        // Initialize the new node's row; as an end node it starts at one.
        if (!last_q) begin
          node_wr_en = 1'b1;
          state_next = S_IDLE;
        end else if (slot_free) begin
          node_wr_en   = 1'b1;
          node_wr_data = {{ALPHABET{1'b0}}, TOTAL_W'(1)};
          state_next   = S_IDLE;
        end
      end

      S_COUNT: begin
        if (slot_free) begin
          node_wr_en   = 1'b1;
          node_wr_data = {node_rd_data[RW-1:TOTAL_W], cand_total};
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A word that reaches its end node is counted and reported here.
    if ((state == S_CLEAR || state == S_COUNT) && last_q && slot_free) begin
      if (cand_better) begin
        top_node_next  = walk;
        top_total_next = cand_total;
      end
      emit                 = 1'b1;
      emit_data.word_node  = NODE_W'(walk);
      emit_data.word_total = cand_total;
      emit_data.best_node  = NODE_W'(top_node_next);
      emit_data.best_total = top_total_next;
      emit_data.status     = STATUS_COUNTED;
      walk_next            = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      walk      <= '0;
      next_free <= (NW+1)'(1);
      top_node  <= '0;
      top_total <= '0;
      dropping  <= 1'b0;
      root_init <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state     <= state_next;
      walk      <= walk_next;
      next_free <= next_free_next;
      top_node  <= top_node_next;
      top_total <= top_total_next;
      dropping  <= dropping_next;
      root_init <= root_init_next;
      last_q    <= last_q_next;
    end
    sym_q  <= sym_q_next;
    slot_q <= slot_q_next;
  end

  // Requests are taken only when no symbol is in progress.
  assign symbol_stall = (state != S_IDLE);

  twfc_ram #(
    .DEPTH (CD),
    .WIDTH (NW)
  ) u_child_mem (
    .clk     (clk),
    .rd_en   (child_rd_en),
    .rd_addr (child_rd_addr),
    .rd_data (child_rd_data),
    .wr_en   (child_wr_en),
    .wr_addr (slot_q),
    .wr_data (fresh)
  );

  twfc_ram #(
    .DEPTH (NODES),
    .WIDTH (RW)
  ) u_node_mem (
    .clk     (clk),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .rd_data (node_rd_data),
    .wr_en   (node_wr_en),
    .wr_addr (node_wr_addr),
    .wr_data (node_wr_data)
  );

  twfc_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .load_data    (emit_data),
    .slot_free    (slot_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (out_data)
  );

  assign word_node  = out_data.word_node;
  assign word_total = out_data.word_total;
  assign best_node  = out_data.best_node;
  assign best_total = out_data.best_total;
  assign status     = out_data.status;

endmodule

// File: rtl/twfc_ram.sv
`timescale 1ns / 1ps
// Single port write, single port read synchronous RAM with registered read data.
// Depends on nothing; used for the child table and the node rows.
module twfc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/twfc_out_reg.sv
`timescale 1ns / 1ps
// Result register between the walk logic and the downstream consumer.
// Depends on twfc_pkg for the result type.
module twfc_out_reg
  import twfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    slot_free,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_data
);

  assign slot_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= load_data;
    end
  end

endmodule
